### rtl/core/assert_macros.svh
// Assertion macros shared by the postfix evaluator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

### rtl/core/psev_pkg.sv
// Package: types, constants and helpers of the postfix evaluator
`timescale 1ns / 1ps

package psev_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int TALLY_W     = 16;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_MOD     = 3'd5,
        OP_XOR     = 3'd6,
        OP_UNKNOWN = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DIV_ZERO  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load_upper;
        logic load_lower;
    } cell_ctrl_t;

    function automatic status_t flag_error(status_t cur, status_t code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage

### rtl/core/psev_cell.sv
// One stack cell: holds an entry and shifts toward either neighbor
`timescale 1ns / 1ps

module psev_cell
    import psev_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] upper_data,
    input  logic [DATA_W-1:0] lower_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load_upper) begin
            value_reg <= upper_data;
        end else if (ctrl.load_lower) begin
            value_reg <= lower_data;
        end
    end

    assign data = value_reg;

endmodule

### rtl/core/psev_divider.sv
// Radix-2 restoring divider on unsigned magnitudes, one bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psev_divider
    import psev_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    div_reg, div_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, div_reg};
        if (start) begin
            cnt_next = DIV_CNT_W'(DATA_W);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `ASSERT_NEVER(a_start_while_busy, aclk, aresetn, start && (cnt_reg != '0), "divider restarted while busy")
    `ASSERT_CLK(a_done_after_last_step, aclk, aresetn, done_reg |-> (cnt_reg == '0), "divider done with steps left")

endmodule

### rtl/core/postfix_stack_evaluator_unit.sv
// Top level: postfix token evaluator on a chain of shifting stack cells
//
//  channel | direction | ports                                        | beat
//  s_      | in        | s_operation, s_operand_value, s_last_token   | one token
//  m_      | out       | m_result_value, m_status                     | one per last token
//
// Push, unrecognized symbol and underflowing operator are handled in the idle state alone.
// Add, sub, xor, mul: operand capture in idle, then cell-chain update in calc.
// Div, mod: calc waits for the one-bit-per-cycle restoring divider; a zero divisor skips it.
// A last token passes through finish, which loads the result register and clears the stack state.
// Tokens are taken while a result waits; a last token holds in finish until any pending result is taken (m_ready).
// Reset (aresetn low, synchronous) clears depth, tallies, error and handshake state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module postfix_stack_evaluator_unit
    import psev_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic signed [DATA_W-1:0] s_operand_value,
    input  logic                     s_last_token,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_result_value,
    output logic [2:0]               m_status
);

    state_t               state_reg, state_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [TALLY_W-1:0]   operand_tally_reg, operand_tally_next;
    logic [TALLY_W-1:0]   operator_tally_reg, operator_tally_next;
    status_t              err_reg, err_next;
    op_t                  op_reg, op_next;
    logic                 last_reg, last_next;
    logic [DATA_W-1:0]    lhs_reg, lhs_next;
    logic [DATA_W-1:0]    rhs_reg, rhs_next;
    logic                 m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]    m_result_reg, m_result_next;
    status_t              m_status_reg, m_status_next;

    logic [DATA_W-1:0]    cell_data [STACK_DEPTH];
    cell_ctrl_t           cell_ctrl [STACK_DEPTH];
    logic [DATA_W-1:0]    top_in;
    logic                 push_en;
    logic                 pop_en;
    logic [DATA_W-1:0]    op_result;
    logic [2*DATA_W-1:0]  product;
    op_t                  in_op;
    status_t              err_final;
    status_t              status_final;

    logic                 div_start;
    logic                 div_done;
    logic [DATA_W-1:0]    div_dividend;
    logic [DATA_W-1:0]    div_divisor;
    logic [DATA_W-1:0]    div_quo;
    logic [DATA_W-1:0]    div_rem;

    assign top_in = push_en ? s_operand_value : op_result;

    assign cell_ctrl[0] = '{load_upper: push_en || pop_en, load_lower: 1'b0};

    for (genvar i = 1; i < STACK_DEPTH; i++) begin : g_ctrl
        assign cell_ctrl[i] = '{load_upper: push_en, load_lower: pop_en};
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] upper_d;
        logic [DATA_W-1:0] lower_d;
        if (i == 0) begin : g_top
            assign upper_d = top_in;
        end else begin : g_mid
            assign upper_d = cell_data[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bottom
            assign lower_d = cell_data[i];
        end else begin : g_inner
            assign lower_d = cell_data[i+1];
        end
        psev_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .upper_data (upper_d),
            .lower_data (lower_d),
            .data       (cell_data[i])
        );
    end

    assign div_dividend = cell_data[1][DATA_W-1] ? (~cell_data[1] + 1'b1) : cell_data[1];
    assign div_divisor  = cell_data[0][DATA_W-1] ? (~cell_data[0] + 1'b1) : cell_data[0];

    psev_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign product = lhs_reg * rhs_reg;
    assign in_op   = op_t'(s_operation);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            depth_reg          <= '0;
            operand_tally_reg  <= '0;
            operator_tally_reg <= '0;
            err_reg            <= ST_OK;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            depth_reg          <= depth_next;
            operand_tally_reg  <= operand_tally_next;
            operator_tally_reg <= operator_tally_next;
            err_reg            <= err_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        last_reg     <= last_next;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
        m_result_reg <= m_result_next;
        m_status_reg <= m_status_next;
    end

    always_comb begin
        state_next          = state_reg;
        depth_next          = depth_reg;
        operand_tally_next  = operand_tally_reg;
        operator_tally_next = operator_tally_reg;
        err_next            = err_reg;
        op_next             = op_reg;
        last_next           = last_reg;
        lhs_next            = lhs_reg;
        rhs_next            = rhs_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_result_next       = m_result_reg;
        m_status_next       = m_status_reg;
        push_en             = 1'b0;
        pop_en              = 1'b0;
        div_start           = 1'b0;
        op_result           = '0;
        s_ready             = (state_reg == S_IDLE);
        err_final           = (depth_reg == '0) ? flag_error(err_reg, ST_UNDERFLOW) : err_reg;
        status_final        = (operand_tally_reg != operator_tally_reg + 1'b1)
                              ? ST_MISMATCH : err_final;

        unique case (op_reg)
            OP_ADD:  op_result = lhs_reg + rhs_reg;
            OP_SUB:  op_result = lhs_reg - rhs_reg;
            OP_MUL:  op_result = product[DATA_W-1:0];
            OP_XOR:  op_result = lhs_reg ^ rhs_reg;
            OP_DIV: begin
                if (rhs_reg == '0) begin
                    op_result = '0;
                end else begin
                    op_result = (lhs_reg[DATA_W-1] ^ rhs_reg[DATA_W-1])
                                ? (~div_quo + 1'b1) : div_quo;
                end
            end
            OP_MOD: begin
                if (rhs_reg == '0) begin
                    op_result = '0;
                end else begin
                    op_result = lhs_reg[DATA_W-1] ? (~div_rem + 1'b1) : div_rem;
                end
            end
            default: op_result = '0;
        endcase

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = in_op;
                    last_next = s_last_token;
                    state_next = s_last_token ? S_FINISH : S_IDLE;
                    if (in_op == OP_PUSH) begin
                        operand_tally_next = operand_tally_reg + 1'b1;
                        if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                            err_next = flag_error(err_reg, ST_OVERFLOW);
                        end else begin
                            push_en    = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end
                    end else begin
                        operator_tally_next = operator_tally_reg + 1'b1;
                        if (in_op != OP_UNKNOWN) begin
                            if (depth_reg < DEPTH_W'(2)) begin
                                err_next = flag_error(err_reg, ST_UNDERFLOW);
                            end else begin
                                lhs_next   = cell_data[1];
                                rhs_next   = cell_data[0];
                                div_start  = (in_op == OP_DIV || in_op == OP_MOD) &&
                                             (cell_data[0] != '0);
                                state_next = S_CALC;
                            end
                        end
                    end
                end
            end
            S_CALC: begin
                if ((op_reg != OP_DIV && op_reg != OP_MOD) || rhs_reg == '0 || div_done) begin
                    pop_en     = 1'b1;
                    depth_next = depth_reg - 1'b1;
                    if ((op_reg == OP_DIV || op_reg == OP_MOD) && rhs_reg == '0) begin
                        err_next = flag_error(err_reg, ST_DIV_ZERO);
                    end
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = status_final;
                    m_result_next       = (status_final == ST_OK) ? cell_data[0] : '0;
                    depth_next          = '0;
                    operand_tally_next  = '0;
                    operator_tally_next = '0;
                    err_next            = ST_OK;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_status       = m_status_reg;

    `ASSERT_NEVER(a_depth_bound, aclk, aresetn, depth_reg > DEPTH_W'(STACK_DEPTH), "stack depth past capacity")
    `ASSERT_CLK(a_finish_clears, aclk, aresetn, (state_reg == S_FINISH && (!m_valid_reg || m_ready)) |=> (depth_reg == '0 && err_reg == ST_OK && m_valid_reg), "state not cleared after last item")
    `ASSERT_CLK(a_div_done_in_calc, aclk, aresetn, div_done |-> (state_reg == S_CALC), "divider result outside calc")
    `ASSERT_CLK(a_error_result_zero, aclk, aresetn, (m_valid_reg && m_status_reg != ST_OK) |-> (m_result_reg == '0), "nonzero result with error status")

endmodule
